// File: rtl/cfa_pkg.sv
// Package for the contiguous frame allocator: widths, codes and defaults.
// No dependencies; the channel interfaces, the top level and the testbench use it.
`default_nettype none
package cfa_pkg;

  localparam int FRAME_W        = 20;
  localparam int CNT_W          = 15;
  localparam int FUNC_W         = 3;
  localparam int STATE_W        = 2;
  localparam int STATUS_W       = 3;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 20;
  localparam int FPW            = 4;   // frames per map word
  localparam int FPW_LG         = 2;
  localparam int DEF_MAX_FRAMES = 16384;
  localparam int CNT_SAT        = 32767;

  // frame states
  localparam logic [STATE_W-1:0] ST_FREE = 2'd0;
  localparam logic [STATE_W-1:0] ST_HEAD = 2'd1;
  localparam logic [STATE_W-1:0] ST_CONT = 2'd2;

  // functions
  localparam logic [FUNC_W-1:0] FN_ALLOC   = 3'd0;
  localparam logic [FUNC_W-1:0] FN_MARK    = 3'd1;
  localparam logic [FUNC_W-1:0] FN_RELEASE = 3'd2;
  localparam logic [FUNC_W-1:0] FN_READ    = 3'd3;
  localparam logic [FUNC_W-1:0] FN_CLEAR   = 3'd4;

  // status codes
  localparam logic [STATUS_W-1:0] SC_OK      = 3'd0;
  localparam logic [STATUS_W-1:0] SC_NOSPACE = 3'd1;
  localparam logic [STATUS_W-1:0] SC_RANGE   = 3'd2;
  localparam logic [STATUS_W-1:0] SC_USED    = 3'd3;
  localparam logic [STATUS_W-1:0] SC_NOTHEAD = 3'd4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BASE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POOL    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RESERVE = 2'd2;

  localparam logic [FRAME_W-1:0] RST_BASE    = 20'd0;
  localparam logic [CNT_W-1:0]   RST_POOL    = 15'd16384;
  localparam logic               RST_RESERVE = 1'b1;

endpackage
`default_nettype wire

// File: rtl/cfa_if.sv
// Channel interfaces of the frame allocator: request, result, config write.
// Depends on cfa_pkg for field widths.
`default_nettype none
interface cfa_in_if;
  logic                         valid;
  logic                         ready;
  logic [cfa_pkg::FUNC_W-1:0]   func;
  logic [cfa_pkg::FRAME_W-1:0]  frame_number;
  logic [cfa_pkg::CNT_W-1:0]    frame_count;
  modport source (output valid, func, frame_number, frame_count, input ready);
  modport sink   (input valid, func, frame_number, frame_count, output ready);
endinterface

interface cfa_out_if;
  logic                          valid;
  logic                          ready;
  logic [cfa_pkg::FRAME_W-1:0]   result_frame;
  logic [cfa_pkg::STATE_W-1:0]   frame_state;
  logic [cfa_pkg::STATUS_W-1:0]  status;
  logic [cfa_pkg::CNT_W-1:0]     free_frames;
  modport source (output valid, result_frame, frame_state, status, free_frames,
                  input ready);
  modport sink   (input valid, result_frame, frame_state, status, free_frames,
                  output ready);
endinterface

interface cfa_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [cfa_pkg::CFG_IDX_W-1:0]   index;
  logic [cfa_pkg::CFG_DATA_W-1:0]  data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// File: rtl/cfa_map_ram.sv
// Frame map storage: one write port, one read port, registered read data.
// Depends on nothing but its parameters.
`default_nettype none
module cfa_map_ram #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12,
  parameter int DW    = 8
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

// File: rtl/contiguous_frame_allocator_unit.sv
// Top level of the contiguous frame allocator: sequencer, registers, result stage.
// Depends on cfa_pkg, cfa_if.sv and cfa_map_ram.
//
// The pool map keeps two bits per frame (free, head, continuation), four frames
// to a word of a single-port-read, single-port-write RAM of MAX_FRAMES/4 words.
// One request is handled at a time. Every map word visited is read, then checked
// or modified and written back. After reset, and on a clear request, a clearing
// pass writes every map word; no request is taken during it, config writes are
// always taken. Allocate scans from the pool start word by word up to the first
// fitting run, then writes the words of that run. Mark checks the words of the
// run, then writes them. Release frees the run word by word; read reads the one
// word of the frame; rejected requests go straight to the result. The result
// sits in an output register until taken; a new request can be taken meanwhile,
// and its result waits for the slot.
`default_nettype none
module contiguous_frame_allocator_unit #(
  parameter int MAX_FRAMES = cfa_pkg::DEF_MAX_FRAMES
) (
  input  wire logic clk,
  input  wire logic rst_n,
  cfa_in_if.sink    in_ch,
  cfa_out_if.source out_ch,
  cfa_cfg_if.sink   cfg_ch
);
  import cfa_pkg::*;

  localparam int IW    = $clog2(MAX_FRAMES);
  localparam int WORDS = MAX_FRAMES / FPW;
  localparam int WAW   = IW - FPW_LG;
  localparam int WDW   = 2 * FPW;
  // position width: holds pool size and start plus count
  localparam int PW    = (((IW + 1) > CNT_W) ? (IW + 1) : CNT_W) + 1;

  typedef enum logic [13:0] {
    S_INIT = 14'b00000000000001,
    S_IDLE = 14'b00000000000010,
    S_DISP = 14'b00000000000100,
    S_ARD  = 14'b00000000001000,
    S_ACHK = 14'b00000000010000,
    S_MRD  = 14'b00000000100000,
    S_MCHK = 14'b00000001000000,
    S_WRD  = 14'b00000010000000,
    S_WMOD = 14'b00000100000000,
    S_FRD  = 14'b00001000000000,
    S_FMOD = 14'b00010000000000,
    S_QRD  = 14'b00100000000000,
    S_QOUT = 14'b01000000000000,
    S_PUSH = 14'b10000000000000
  } state_t;

  state_t state_r, state_nxt;

  // configuration
  logic [FRAME_W-1:0] base_r;
  logic [CNT_W-1:0]   pool_r;
  logic               resv_r;

  // latched request
  logic [FUNC_W-1:0]  func_r;
  logic [FRAME_W-1:0] fno_r;
  logic [CNT_W-1:0]   cnt_r;

  // work registers
  logic [PW-1:0]      cur_r, cur_nxt;
  logic [PW-1:0]      run_r, run_nxt;
  logic [PW-1:0]      start_r, start_nxt;
  logic [CNT_W-1:0]   fc_r, fc_nxt;
  logic               clr_push_r, clr_push_nxt;
  logic [FRAME_W-1:0] rs_frame_r, rs_frame_nxt;
  logic [STATE_W-1:0] rs_state_r, rs_state_nxt;
  logic [STATUS_W-1:0] rs_status_r, rs_status_nxt;

  // result stage
  logic                out_valid_r;
  logic [FRAME_W-1:0]  out_frame_r;
  logic [STATE_W-1:0]  out_state_r;
  logic [STATUS_W-1:0] out_status_r;
  logic [CNT_W-1:0]    out_free_r;
  logic                push_go;

  // map RAM
  logic           mem_we;
  logic [WAW-1:0] mem_waddr, mem_raddr;
  logic [WDW-1:0] mem_wdata, mem_rdata;

  cfa_map_ram #(.DEPTH(WORDS), .AW(WAW), .DW(WDW)) u_map (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // derived values
  logic [PW-1:0]      n_p, cnt_p, end_p, next_p, off_p, align_p;
  logic [FRAME_W-1:0] off20, n20;
  logic               below;
  logic               in_acc, out_acc;

  assign n_p    = (PW'(pool_r) < PW'(MAX_FRAMES)) ? PW'(pool_r) : PW'(MAX_FRAMES);
  assign cnt_p  = PW'(cnt_r);
  assign end_p  = start_r + cnt_p;
  assign next_p = cur_r + PW'(FPW);
  assign off20  = fno_r - base_r;
  assign n20    = FRAME_W'(n_p);
  assign below  = fno_r < base_r;
  assign off_p  = PW'(off20);
  assign align_p = off_p & ~PW'(FPW - 1);

  assign in_acc  = in_ch.valid && in_ch.ready;
  assign out_acc = out_ch.valid && out_ch.ready;

  assign in_ch.ready  = (state_r == S_IDLE);
  assign cfg_ch.ready = 1'b1;

  assign out_ch.valid        = out_valid_r;
  assign out_ch.result_frame = out_frame_r;
  assign out_ch.frame_state  = out_state_r;
  assign out_ch.status       = out_status_r;
  assign out_ch.free_frames  = out_free_r;

  // sequencer
  always_comb begin
    logic [PW-1:0]      pos_v;
    logic [PW-1:0]      run_v;
    logic [PW-1:0]      fstart_v;
    logic               found_v;
    logic               stop_v;
    logic               used_v;
    logic               go_v;
    logic               nothead_v;
    logic [2:0]         freed_v;
    logic [WDW-1:0]     word_v;
    logic [STATE_W-1:0] st_v;
    logic [CNT_W:0]     sum_v;

    state_nxt     = state_r;
    cur_nxt       = cur_r;
    run_nxt       = run_r;
    start_nxt     = start_r;
    fc_nxt        = fc_r;
    clr_push_nxt  = clr_push_r;
    rs_frame_nxt  = rs_frame_r;
    rs_state_nxt  = rs_state_r;
    rs_status_nxt = rs_status_r;
    push_go       = 1'b0;
    mem_we        = 1'b0;
    mem_waddr     = cur_r[IW-1:FPW_LG];
    mem_raddr     = cur_r[IW-1:FPW_LG];
    mem_wdata     = '0;
    run_v         = run_r;
    fstart_v      = '0;
    found_v       = 1'b0;
    stop_v        = 1'b0;
    used_v        = 1'b0;
    go_v          = 1'b1;
    nothead_v     = 1'b0;
    freed_v       = '0;
    word_v        = mem_rdata;
    pos_v         = cur_r;
    st_v          = ST_FREE;
    sum_v         = '0;

    unique case (state_r)
      S_INIT: begin
        // sweep the map; reserve the first frame if asked
        mem_we = 1'b1;
        if (cur_r == '0 && resv_r && n_p != '0) begin
          mem_wdata = WDW'(ST_HEAD);
        end
        if (next_p >= PW'(MAX_FRAMES)) begin
          fc_nxt = (resv_r && n_p != '0) ? CNT_W'(n_p - PW'(1)) : CNT_W'(n_p);
          state_nxt = clr_push_r ? S_PUSH : S_IDLE;
        end else begin
          cur_nxt = next_p;
        end
      end

      S_IDLE: begin
        if (in_acc) begin
          state_nxt = S_DISP;
        end
      end

      S_DISP: begin
        rs_frame_nxt  = '0;
        rs_state_nxt  = ST_FREE;
        rs_status_nxt = SC_OK;
        state_nxt     = S_PUSH;
        case (func_r)
          FN_ALLOC: begin
            if (cnt_r == '0) begin
              rs_status_nxt = SC_RANGE;
            end else if (cnt_p > n_p) begin
              rs_status_nxt = SC_NOSPACE;
            end else begin
              cur_nxt   = '0;
              run_nxt   = '0;
              state_nxt = S_ARD;
            end
          end
          FN_MARK: begin
            if (cnt_r == '0 || below || off20 > n20 ||
                FRAME_W'(cnt_r) > (n20 - off20)) begin
              rs_status_nxt = SC_RANGE;
            end else begin
              start_nxt = off_p;
              cur_nxt   = align_p;
              state_nxt = S_MRD;
            end
          end
          FN_RELEASE: begin
            if (below || off20 >= n20) begin
              rs_status_nxt = SC_RANGE;
            end else begin
              start_nxt = off_p;
              cur_nxt   = align_p;
              state_nxt = S_FRD;
            end
          end
          FN_READ: begin
            if (below || off20 >= n20) begin
              rs_status_nxt = SC_RANGE;
            end else begin
              start_nxt = off_p;
              cur_nxt   = align_p;
              state_nxt = S_QRD;
            end
          end
          FN_CLEAR: begin
            cur_nxt      = '0;
            clr_push_nxt = 1'b1;
            state_nxt    = S_INIT;
          end
          default: begin
            rs_status_nxt = SC_RANGE;
          end
        endcase
      end

      S_ARD: state_nxt = S_ACHK;

      S_ACHK: begin
        // first fit: extend the free run frame by frame
        for (int j = 0; j < FPW; j++) begin
          pos_v = cur_r + PW'(j);
          st_v  = mem_rdata[2*j +: 2];
          if (!found_v && !stop_v) begin
            if (pos_v < n_p) begin
              run_v = (st_v == ST_FREE) ? run_v + PW'(1) : '0;
              if (run_v == cnt_p) begin
                found_v  = 1'b1;
                fstart_v = pos_v + PW'(1) - cnt_p;
              end
            end else begin
              stop_v = 1'b1;
            end
          end
        end
        if (found_v) begin
          start_nxt = fstart_v;
          cur_nxt   = fstart_v & ~PW'(FPW - 1);
          state_nxt = S_WRD;
        end else if (next_p >= n_p) begin
          rs_status_nxt = SC_NOSPACE;
          state_nxt     = S_PUSH;
        end else begin
          cur_nxt   = next_p;
          run_nxt   = run_v;
          state_nxt = S_ARD;
        end
      end

      S_MRD: state_nxt = S_MCHK;

      S_MCHK: begin
        for (int j = 0; j < FPW; j++) begin
          pos_v = cur_r + PW'(j);
          if (pos_v >= start_r && pos_v < end_p && mem_rdata[2*j +: 2] != ST_FREE) begin
            used_v = 1'b1;
          end
        end
        if (used_v) begin
          rs_status_nxt = SC_USED;
          state_nxt     = S_PUSH;
        end else if (next_p >= end_p) begin
          cur_nxt   = start_r & ~PW'(FPW - 1);
          state_nxt = S_WRD;
        end else begin
          cur_nxt   = next_p;
          state_nxt = S_MRD;
        end
      end

      S_WRD: state_nxt = S_WMOD;

      S_WMOD: begin
        // write head and continuations of the run
        for (int j = 0; j < FPW; j++) begin
          pos_v = cur_r + PW'(j);
          if (pos_v >= start_r && pos_v < end_p) begin
            word_v[2*j +: 2] = (pos_v == start_r) ? ST_HEAD : ST_CONT;
          end
        end
        mem_we    = 1'b1;
        mem_wdata = word_v;
        if (next_p >= end_p) begin
          fc_nxt       = (fc_r > cnt_r) ? fc_r - cnt_r : '0;
          rs_frame_nxt = base_r + FRAME_W'(start_r);
          state_nxt    = S_PUSH;
        end else begin
          cur_nxt   = next_p;
          state_nxt = S_WRD;
        end
      end

      S_FRD: state_nxt = S_FMOD;

      S_FMOD: begin
        // free the head, then continuations until a non-continuation
        for (int j = 0; j < FPW; j++) begin
          pos_v = cur_r + PW'(j);
          st_v  = mem_rdata[2*j +: 2];
          if (pos_v >= start_r && go_v) begin
            if (pos_v == start_r) begin
              if (st_v != ST_HEAD) begin
                nothead_v = 1'b1;
                go_v      = 1'b0;
              end else begin
                word_v[2*j +: 2] = ST_FREE;
                freed_v          = freed_v + 3'd1;
              end
            end else if (pos_v < n_p && st_v == ST_CONT) begin
              word_v[2*j +: 2] = ST_FREE;
              freed_v          = freed_v + 3'd1;
            end else begin
              go_v = 1'b0;
            end
          end
        end
        if (nothead_v) begin
          rs_status_nxt = SC_NOTHEAD;
          state_nxt     = S_PUSH;
        end else begin
          mem_we    = 1'b1;
          mem_wdata = word_v;
          sum_v     = {1'b0, fc_r} + (CNT_W+1)'(freed_v);
          fc_nxt    = (sum_v > (CNT_W+1)'(CNT_SAT)) ? CNT_W'(CNT_SAT) : sum_v[CNT_W-1:0];
          if (go_v && next_p < n_p) begin
            cur_nxt   = next_p;
            state_nxt = S_FRD;
          end else begin
            state_nxt = S_PUSH;
          end
        end
      end

      S_QRD: state_nxt = S_QOUT;

      S_QOUT: begin
        rs_state_nxt = mem_rdata[2*start_r[FPW_LG-1:0] +: 2];
        state_nxt    = S_PUSH;
      end

      S_PUSH: begin
        // hold until the output slot is free
        if (!out_valid_r || out_ch.ready) begin
          push_go      = 1'b1;
          clr_push_nxt = 1'b0;
          state_nxt    = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      cur_r       <= '0;
      clr_push_r  <= 1'b0;
      out_valid_r <= 1'b0;
      base_r      <= RST_BASE;
      pool_r      <= RST_POOL;
      resv_r      <= RST_RESERVE;
      fc_r        <= '0;
    end else begin
      state_r    <= state_nxt;
      cur_r      <= cur_nxt;
      clr_push_r <= clr_push_nxt;
      fc_r       <= fc_nxt;
      if (push_go) begin
        out_valid_r <= 1'b1;
      end else if (out_acc) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          REG_BASE:    base_r <= cfg_ch.data[FRAME_W-1:0];
          REG_POOL:    pool_r <= cfg_ch.data[CNT_W-1:0];
          REG_RESERVE: resv_r <= cfg_ch.data[0];
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    run_r       <= run_nxt;
    start_r     <= start_nxt;
    rs_frame_r  <= rs_frame_nxt;
    rs_state_r  <= rs_state_nxt;
    rs_status_r <= rs_status_nxt;
    if (in_acc) begin
      func_r <= in_ch.func;
      fno_r  <= in_ch.frame_number;
      cnt_r  <= in_ch.frame_count;
    end
    if (push_go) begin
      out_frame_r  <= rs_frame_r;
      out_state_r  <= rs_state_r;
      out_status_r <= rs_status_r;
      out_free_r   <= fc_r;
    end
  end

  // checks
  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE || state_r == S_PUSH) |-> !mem_we)
    else $error("map written outside a work state");

  a_valid_from_push: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_PUSH))
    else $error("result raised outside the push state");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r == S_DISP)
    else $error("accepted request not dispatched");

endmodule
`default_nettype wire

// File: tb/sv/tb_contiguous_frame_allocator_unit.sv
// Self-checking testbench for contiguous_frame_allocator_unit: requests go in,
// results are compared field by field against a behavioral pool map predictor.
// Depends on cfa_pkg and the channel interfaces in cfa_if.sv.
module tb_contiguous_frame_allocator_unit;
  import cfa_pkg::*;

  typedef struct packed {
    logic [FUNC_W-1:0]  func;
    logic [FRAME_W-1:0] fno;
    logic [CNT_W-1:0]   cnt;
  } alloc_req_t;

  typedef struct packed {
    logic [FRAME_W-1:0]  frame;
    logic [STATE_W-1:0]  fstate;
    logic [STATUS_W-1:0] status;
    logic [CNT_W-1:0]    nfree;
  } alloc_rsp_t;

  localparam int LIMIT_CYCLES = 6000000;

  logic clk;
  logic rst_n;

  cfa_in_if  in_ch();
  cfa_out_if out_ch();
  cfa_cfg_if cfg_ch();

  contiguous_frame_allocator_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // Shadow of the pool: one state per frame, the free counter, the registers.
  logic [STATE_W-1:0] pool_map [0:DEF_MAX_FRAMES-1];
  int                 pool_free;
  logic [FRAME_W-1:0] reg_base;
  logic [CNT_W-1:0]   reg_pool;
  logic               reg_reserve;

  alloc_req_t pending_reqs[$];
  alloc_rsp_t expected_rsps[$];

  bit  steady;       // while set, neither side idles
  bit  in_taken;     // input transaction completed at the last rising edge
  int  mismatches;
  int  rsp_count;
  int  req_count;
  int  cycles;

  function automatic int pool_size();
    return (reg_pool < DEF_MAX_FRAMES) ? int'(reg_pool) : DEF_MAX_FRAMES;
  endfunction

  function automatic void clear_pool();
    int n;
    n = pool_size();
    for (int i = 0; i < DEF_MAX_FRAMES; i++) pool_map[i] = ST_FREE;
    pool_free = n;
    if (reg_reserve && n > 0) begin
      pool_map[0] = ST_HEAD;
      pool_free = n - 1;
    end
  endfunction

  function automatic void claim_run(int start, int cnt);
    pool_map[start] = ST_HEAD;
    for (int k = 1; k < cnt; k++) pool_map[start + k] = ST_CONT;
    pool_free = (pool_free > cnt) ? pool_free - cnt : 0;
  endfunction

  // Advance the shadow pool by one request and return the result it yields.
  function automatic alloc_rsp_t predict_pool_op(alloc_req_t r);
    alloc_rsp_t         o;
    int                 n, cnt, off, run, start, k, i;
    bit                 below, found;
    logic [FRAME_W-1:0] offv;
    n     = pool_size();
    cnt   = int'(r.cnt);
    offv  = r.fno - reg_base;
    off   = int'(offv);
    below = r.fno < reg_base;
    o     = '0;
    o.status = SC_OK;
    case (r.func)
      FN_ALLOC: begin
        if (cnt == 0) begin
          o.status = SC_RANGE;
        end else begin
          run = 0; found = 0; start = 0;
          if (cnt <= n) begin
            for (i = 0; i < n && !found; i++) begin
              run = (pool_map[i] == ST_FREE) ? run + 1 : 0;
              if (run == cnt) begin
                start = i + 1 - cnt;
                found = 1;
              end
            end
          end
          if (found) begin
            claim_run(start, cnt);
            o.frame = reg_base + FRAME_W'(start);
          end else begin
            o.status = SC_NOSPACE;
          end
        end
      end
      FN_MARK: begin
        if (cnt == 0 || below || off > n || cnt > n - off) begin
          o.status = SC_RANGE;
        end else begin
          for (k = 0; k < cnt; k++)
            if (pool_map[off + k] != ST_FREE) break;
          if (k != cnt) begin
            o.status = SC_USED;
          end else begin
            claim_run(off, cnt);
            o.frame = r.fno;
          end
        end
      end
      FN_RELEASE: begin
        if (below || off >= n) begin
          o.status = SC_RANGE;
        end else if (pool_map[off] != ST_HEAD) begin
          o.status = SC_NOTHEAD;
        end else begin
          i = off;
          do begin
            pool_map[i] = ST_FREE;
            if (pool_free < CNT_SAT) pool_free++;
            i++;
          end while (i < n && pool_map[i] == ST_CONT);
        end
      end
      FN_READ: begin
        if (below || off >= n) o.status = SC_RANGE;
        else o.fstate = pool_map[off];
      end
      FN_CLEAR: clear_pool();
      default: o.status = SC_RANGE;
    endcase
    o.nfree = CNT_W'(pool_free);
    return o;
  endfunction

  // Find a head at or after a random offset, wrapping; -1 when none.
  function automatic int pick_head(int n);
    int s;
    if (n == 0) return -1;
    s = $urandom_range(n - 1);
    for (int k = 0; k < n; k++)
      if (pool_map[(s + k) % n] == ST_HEAD) return (s + k) % n;
    return -1;
  endfunction

  function automatic int small_count(int n);
    int hi;
    hi = (n < 8) ? ((n < 1) ? 1 : n) : 8;
    return $urandom_range(hi, 1);
  endfunction

  // Build one random request, mostly well formed against the current pool.
  function automatic alloc_req_t make_req();
    alloc_req_t r;
    int         n, pick, off;
    n    = pool_size();
    pick = $urandom_range(99);
    r.fno = FRAME_W'($urandom);
    r.cnt = CNT_W'($urandom);
    if (pick < 32) begin
      r.func = FN_ALLOC;
      if ($urandom_range(9) != 0) r.cnt = CNT_W'(small_count(n));
    end else if (pick < 47) begin
      r.func = FN_MARK;
      if ($urandom_range(9) != 0) begin
        r.cnt = CNT_W'(small_count(n));
        off   = $urandom_range(n + 2);
        r.fno = reg_base + FRAME_W'(off);
        if (reg_base != 0 && $urandom_range(7) == 0)
          r.fno = reg_base - FRAME_W'($urandom_range(3, 1));
      end
    end else if (pick < 72) begin
      r.func = FN_RELEASE;
      off = pick_head(n);
      if ($urandom_range(7) != 0 && off >= 0) r.fno = reg_base + FRAME_W'(off);
      else if ($urandom_range(1)) r.fno = reg_base + FRAME_W'($urandom_range(n + 2));
    end else if (pick < 93) begin
      r.func = FN_READ;
      if ($urandom_range(7) != 0) r.fno = reg_base + FRAME_W'($urandom_range(n + 3));
    end else if (pick < 95) begin
      r.func = FN_CLEAR;
    end else begin
      r.func = FUNC_W'($urandom_range(7, 5));
    end
    return r;
  endfunction

  // Clock and counters; the cycle limit ends a hung run.
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results still awaited",
               cycles, expected_rsps.size());
      $display("** contiguous_frame_allocator_unit: FAILED **");
      $finish;
    end
  end

  // Request side: record completed transactions and predict their results.
  always @(posedge clk) begin
    in_taken = in_ch.valid && in_ch.ready;
    if (rst_n && in_taken) begin
      expected_rsps.push_back(predict_pool_op({in_ch.func, in_ch.frame_number,
                                               in_ch.frame_count}));
      req_count++;
    end
  end

  // Request driver: hold an offered item until taken, then pull the next one.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (in_ch.valid && !in_taken) begin
      in_ch.valid <= 1'b1;
    end else if (pending_reqs.size() > 0 && (steady || $urandom_range(99) >= 37)) begin
      alloc_req_t r;
      r = pending_reqs.pop_front();
      in_ch.valid        <= 1'b1;
      in_ch.func         <= r.func;
      in_ch.frame_number <= r.fno;
      in_ch.frame_count  <= r.cnt;
    end else begin
      in_ch.valid <= 1'b0;
    end
  end

  // Result side: stall at random, except during the steady stretch.
  always @(negedge clk) begin
    out_ch.ready <= rst_n && (steady || $urandom_range(99) >= 37);
  end

  // Monitor: compare each result with the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      rsp_count++;
      if (expected_rsps.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result frame=%h status=%0d", out_ch.result_frame,
                   out_ch.status);
      end else begin
        alloc_rsp_t e;
        e = expected_rsps.pop_front();
        if (e.frame !== out_ch.result_frame || e.fstate !== out_ch.frame_state ||
            e.status !== out_ch.status || e.nfree !== out_ch.free_frames) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result %0d: expected frame=%h state=%0d status=%0d free=%0d, got frame=%h state=%0d status=%0d free=%0d",
                     rsp_count, e.frame, e.fstate, e.status, e.nfree,
                     out_ch.result_frame, out_ch.frame_state, out_ch.status,
                     out_ch.free_frames);
        end
      end
    end
  end

  // Write one register; the shadow copy changes at the same edge.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      REG_BASE:    reg_base    = data[FRAME_W-1:0];
      REG_POOL:    reg_pool    = data[CNT_W-1:0];
      REG_RESERVE: reg_reserve = data[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // Wait until every queued request is taken and every result has come back.
  task automatic drain();
    while (pending_reqs.size() > 0 || expected_rsps.size() > 0 || in_ch.valid)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic push_req(logic [FUNC_W-1:0] f, logic [FRAME_W-1:0] fno,
                          logic [CNT_W-1:0] cnt);
    alloc_req_t r;
    r.func = f; r.fno = fno; r.cnt = cnt;
    pending_reqs.push_back(r);
  endtask

  // Random traffic in small batches so release and mark targets track the map.
  task automatic run_random(int total);
    int left;
    left = total;
    while (left > 0) begin
      for (int k = 0; k < 10 && left > 0; k++, left--) pending_reqs.push_back(make_req());
      drain();
    end
  endtask

  // Reprogram the pool, then start it fresh with a clear.
  task automatic new_pool(logic [FRAME_W-1:0] base, logic [CFG_DATA_W-1:0] size,
                          logic [CFG_DATA_W-1:0] rsv, int total);
    write_reg(REG_BASE, base);
    write_reg(REG_POOL, size);
    write_reg(REG_RESERVE, rsv);
    push_req(FN_CLEAR, '0, '0);
    drain();
    run_random(total);
  endtask

  initial begin
    rst_n        = 1'b0;
    steady       = 1'b0;
    in_taken     = 1'b0;
    mismatches   = 0;
    rsp_count    = 0;
    req_count    = 0;
    cycles       = 0;
    in_ch.valid  = 1'b0;
    in_ch.func   = '0;
    in_ch.frame_number = '0;
    in_ch.frame_count  = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data  = '0;
    reg_base     = RST_BASE;
    reg_pool     = RST_POOL;
    reg_reserve  = RST_RESERVE;
    clear_pool();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: every function and each corner, on the reset pool.
    push_req(FN_READ,    20'd0,     15'd0);      // reserved head
    push_req(FN_ALLOC,   20'd0,     15'd0);      // zero count
    push_req(FN_ALLOC,   20'd0,     15'd1);
    push_req(FN_ALLOC,   20'd0,     15'd3);
    push_req(FN_READ,    20'd2,     15'd0);      // head of the three-frame run
    push_req(FN_READ,    20'd5,     15'd0);      // free
    push_req(FN_ALLOC,   20'd0,     15'd16384);  // no fitting run
    push_req(FN_ALLOC,   20'd0,     15'h7FFF);   // larger than the pool
    push_req(FN_MARK,    20'd100,   15'd4);
    push_req(FN_MARK,    20'd102,   15'd4);      // over used frames
    push_req(FN_MARK,    20'd0,     15'd0);      // zero count
    push_req(FN_MARK,    20'd16380, 15'd5);      // runs past the pool end
    push_req(FN_MARK,    20'd16380, 15'd4);      // ends exactly at the pool end
    push_req(FN_MARK,    20'hFFFFF, 15'h7FFF);
    push_req(FN_RELEASE, 20'd101,   15'd0);      // not a head
    push_req(FN_RELEASE, 20'd100,   15'd0);
    push_req(FN_RELEASE, 20'd16380, 15'd0);      // stops at the pool end
    push_req(FN_RELEASE, 20'd16384, 15'd0);      // outside the pool
    push_req(FN_READ,    20'hFFFFF, 15'd0);
    push_req(FN_READ,    20'd16383, 15'd0);
    push_req(3'd5,       20'd0,     15'd0);      // unknown functions
    push_req(3'd6,       20'hAAAAA, 15'h5555);
    push_req(3'd7,       20'h55555, 15'h2AAA);
    push_req(FN_CLEAR,   20'd0,     15'd0);
    drain();
    run_random(20);

    // Pool at the top of the frame space: it ends at the last frame number.
    new_pool(20'hFFFF0, 20'd16, 20'd0, 300);
    // Empty pool: nothing reserved, nothing fits.
    new_pool(20'd0, 20'd0, 20'd1, 40);
    // Steady stretch: neither side idles.
    steady = 1'b1;
    new_pool(20'd12345, 20'd64, 20'd1, 280);
    steady = 1'b0;
    new_pool(20'h80000, 20'd256, 20'd0, 280);
    new_pool(20'hAAAAA, 20'd4, 20'd1, 280);
    new_pool(20'h55555, 20'd128, 20'd0, 280);
    // Oversized register: effective size is the map size.
    new_pool(20'd7, 20'h7FFF, 20'd1, 12);
    // Registers change without a clear: the old map stays in use.
    write_reg(REG_POOL, 20'd32);
    write_reg(REG_BASE, 20'd3);
    run_random(60);

    drain();
    repeat (50) @(posedge clk);
    $display("covered %0d requests and %0d results over nine pool settings,",
             req_count, rsp_count);
    $display("including a wrapped base, an empty pool and an oversized pool");
    if (mismatches == 0 && expected_rsps.size() == 0) begin
      $display("** contiguous_frame_allocator_unit: PASSED **");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, expected_rsps.size());
      $display("** contiguous_frame_allocator_unit: FAILED **");
    end
    $finish;
  end

endmodule
